[sv/utf8v_pkg.sv]
package utf8v_pkg;

   // Rule codes for the byte that follows a three- or four-byte lead
   localparam logic [2:0] RULE_NONE   = 3'd0;
   localparam logic [2:0] RULE_MIN_A0 = 3'd1;
   localparam logic [2:0] RULE_MAX_9F = 3'd2;
   localparam logic [2:0] RULE_MIN_90 = 3'd3;
   localparam logic [2:0] RULE_MAX_8F = 3'd4;

   // Byte values that bound the lead and continuation ranges
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] ASCII_MAX  = 8'h7F;
   localparam logic [7:0] LEAD2_MIN  = 8'hC2;
   localparam logic [7:0] LEAD2_MAX  = 8'hDF;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD3_MAX  = 8'hEF;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD4_MAX  = 8'hF4;
   localparam logic [7:0] LEAD3_SURR = 8'hED;
   localparam logic [7:0] BOUND_A0   = 8'hA0;
   localparam logic [7:0] BOUND_9F   = 8'h9F;
   localparam logic [7:0] BOUND_90   = 8'h90;
   localparam logic [7:0] BOUND_8F   = 8'h8F;

   // Decoder state carried from one item to the next
   typedef struct packed {
      logic [1:0] pending_count;
      logic [2:0] second_rule;
      logic       error_seen;
   } utf8v_state_type;

   localparam utf8v_state_type STATE_RESET = '{
      pending_count: 2'd0,
      second_rule:   RULE_NONE,
      error_seen:    1'b0
   };

endpackage

[sv/utf8v_step.sv]
module utf8v_step
   import utf8v_pkg::*;
(
   input  utf8v_state_type state_cur,
   input  logic [7:0]      data_byte,
   output utf8v_state_type state_nxt,
   output logic            text_ok
);

   logic is_cont;
   logic rule_ok;

   // Check the byte against the rule left by the lead byte
   always_comb begin
      is_cont = (data_byte & CONT_MASK) == CONT_TAG;
      case (state_cur.second_rule)
         RULE_MIN_A0: rule_ok = data_byte >= BOUND_A0;
         RULE_MAX_9F: rule_ok = data_byte <= BOUND_9F;
         RULE_MIN_90: rule_ok = data_byte >= BOUND_90;
         RULE_MAX_8F: rule_ok = data_byte <= BOUND_8F;
         default:     rule_ok = 1'b1;
      endcase
   end

   // Advance the decoder by one byte
   always_comb begin
      state_nxt = state_cur;
      if (data_byte == 8'd0) begin
         state_nxt.error_seen = 1'b1;
      end
      if (state_cur.pending_count != 2'd0) begin
         // expecting a continuation: drop the sequence on a mismatch
         if (!is_cont || !rule_ok) begin
            state_nxt.error_seen    = 1'b1;
            state_nxt.pending_count = 2'd0;
         end else begin
            state_nxt.pending_count = state_cur.pending_count - 2'd1;
         end
         state_nxt.second_rule = RULE_NONE;
      end else if (data_byte <= ASCII_MAX) begin
         // single-byte character: nothing to track
      end else if (data_byte inside {[LEAD2_MIN:LEAD2_MAX]}) begin
         state_nxt.pending_count = 2'd1;
         state_nxt.second_rule   = RULE_NONE;
      end else if (data_byte inside {[LEAD3_MIN:LEAD3_MAX]}) begin
         state_nxt.pending_count = 2'd2;
         if (data_byte == LEAD3_MIN) begin
            state_nxt.second_rule = RULE_MIN_A0;
         end else if (data_byte == LEAD3_SURR) begin
            state_nxt.second_rule = RULE_MAX_9F;
         end else begin
            state_nxt.second_rule = RULE_NONE;
         end
      end else if (data_byte inside {[LEAD4_MIN:LEAD4_MAX]}) begin
         state_nxt.pending_count = 2'd3;
         if (data_byte == LEAD4_MIN) begin
            state_nxt.second_rule = RULE_MIN_90;
         end else if (data_byte == LEAD4_MAX) begin
            state_nxt.second_rule = RULE_MAX_8F;
         end else begin
            state_nxt.second_rule = RULE_NONE;
         end
      end else begin
         // stray continuation, overlong two-byte lead or lead beyond U+10FFFF
         state_nxt.error_seen = 1'b1;
      end
      text_ok = !state_nxt.error_seen && (state_nxt.pending_count == 2'd0);
   end

endmodule

[sv/utf8v_stream_validator_unit.sv]
// Strict UTF-8 (RFC 3629) checker for a byte stream that also rejects zero
// bytes. One byte is taken per item, and req_ready stays high while the output
// stage has room, so a byte can be taken in every clock cycle; the decode of a
// byte is combinational compare logic feeding the decoder state registers.
// The item carrying req_last_byte registers one result for rsp_text_valid and
// returns the decoder to its reset state, so the next text can start in the
// following cycle. A two-entry output register (result plus skid) holds up to
// two results while the consumer stalls; req_ready drops only when both are
// full. Errors are sticky until the end of the text.
module utf8_stream_validator_unit
   import utf8v_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_text_valid
);

   utf8v_state_type state_ff;
   utf8v_state_type state_in;
   utf8v_state_type state_step;
   logic            step_ok;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_text_ff,  rsp_text_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_text_ff,  skid_text_in;

   logic req_fire;
   logic rsp_fire;
   logic new_result;

   utf8v_step u_step (
      .state_cur (state_ff),
      .data_byte (req_data_byte),
      .state_nxt (state_step),
      .text_ok   (step_ok)
   );

   assign req_ready      = !skid_valid_ff;
   assign req_fire       = req_valid && req_ready;
   assign rsp_fire       = rsp_valid_ff && rsp_ready;
   assign new_result     = req_fire && req_last_byte;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_text_valid = rsp_text_ff;

   // Advance the decoder state; clear it after the final byte of a text
   always_comb begin
      state_in = state_ff;
      if (req_fire) begin
         state_in = req_last_byte ? STATE_RESET : state_step;
      end
   end

   // Hold results in the output register and spill into the skid stage
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_text_in   = rsp_text_ff;
      skid_valid_in = skid_valid_ff;
      skid_text_in  = skid_text_ff;
      if (!rsp_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_text_in   = skid_text_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = new_result;
            rsp_text_in  = step_ok;
         end
      end else if (new_result) begin
         skid_valid_in = 1'b1;
         skid_text_in  = step_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_RESET;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_text_ff  <= rsp_text_in;
      skid_text_ff <= skid_text_in;
   end

endmodule
